FILE: hdl/resize_request_debouncer_core_defines.svh
// Assertion macros for the resize request debouncer.
`ifndef RESIZE_REQUEST_DEBOUNCER_CORE_DEFINES_SVH
`define RESIZE_REQUEST_DEBOUNCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rrd assertion failed");
`define RRD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rrd assertion failed");
`else
`define RRD_ASSERT(lbl, clk, rst_n, prop)
`define RRD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: hdl/rrd_pkg.sv
`default_nettype none
package rrd_pkg;

	localparam int DIM_BITS  = 16;
	localparam int TIME_BITS = 32;
	localparam int WIN_BITS  = 32;
	localparam int CMP_BITS  = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

	localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(1000);

	localparam logic [1:0] CMD_REQUEST = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_FLUSH   = 2'd2;
	localparam logic [1:0] CMD_RESET   = 2'd3;

	typedef struct packed {
		logic [1:0]                 command;
		logic signed [DIM_BITS-1:0] req_width;
		logic signed [DIM_BITS-1:0] req_height;
		logic [TIME_BITS-1:0]       now_ticks;
	} in_item_t;

	typedef struct packed {
		logic                       applied;
		logic signed [DIM_BITS-1:0] out_width;
		logic signed [DIM_BITS-1:0] out_height;
		logic                       pending_flag;
		logic [WIN_BITS-1:0]        ticks_left;
	} out_item_t;

endpackage
`default_nettype wire

FILE: hdl/rrd_in_stage.sv
`default_nettype none
module rrd_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rrd_pkg::in_item_t in_data,
	input  wire logic              advance,
	output logic                   valid_s1,
	output rrd_pkg::in_item_t      item_s1
);
	import rrd_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/rrd_update.sv
`default_nettype none
module rrd_update (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 fire,
	input  wire rrd_pkg::in_item_t    item,
	input  wire logic                 cfg_we,
	input  wire logic [rrd_pkg::WIN_BITS-1:0] cfg_wdata,
	output rrd_pkg::out_item_t        result
);
	import rrd_pkg::*;

	logic [WIN_BITS-1:0]        window_q;
	logic signed [DIM_BITS-1:0] eff_w_q, eff_h_q, pend_w_q, pend_h_q;
	logic                       waiting_q;
	logic [TIME_BITS-1:0]       last_q;

	logic signed [DIM_BITS-1:0] eff_w_d, eff_h_d, pend_w_d, pend_h_d;
	logic                       waiting_d;
	logic [TIME_BITS-1:0]       last_d;
	logic                       applied;
	logic                       req_pos;
	logic [TIME_BITS-1:0]       el_cur, el_new;
	logic [CMP_BITS-1:0]        win_ext, el_cur_ext, el_new_ext, left_ext;

	assign req_pos = !item.req_width[DIM_BITS-1] && (item.req_width != '0) &&
		!item.req_height[DIM_BITS-1] && (item.req_height != '0);
	assign win_ext    = CMP_BITS'(window_q);
	assign el_cur     = item.now_ticks - last_q;
	assign el_cur_ext = CMP_BITS'(el_cur);

	always_comb begin
		eff_w_d   = eff_w_q;
		eff_h_d   = eff_h_q;
		pend_w_d  = pend_w_q;
		pend_h_d  = pend_h_q;
		waiting_d = waiting_q;
		last_d    = last_q;
		applied   = 1'b0;
		unique case (item.command)
			CMD_REQUEST: begin
				if (req_pos) begin
					if (item.req_width == eff_w_q && item.req_height == eff_h_q) begin
						if (waiting_q) begin
							waiting_d = 1'b0;
							pend_w_d  = item.req_width;
							pend_h_d  = item.req_height;
						end
					end else if (!waiting_q || item.req_width != pend_w_q ||
						item.req_height != pend_h_q) begin
						pend_w_d  = item.req_width;
						pend_h_d  = item.req_height;
						last_d    = item.now_ticks;
						waiting_d = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				if (waiting_q && el_cur_ext >= win_ext) begin
					eff_w_d   = pend_w_q;
					eff_h_d   = pend_h_q;
					waiting_d = 1'b0;
					applied   = 1'b1;
				end
			end
			CMD_FLUSH: begin
				if (waiting_q) begin
					eff_w_d   = pend_w_q;
					eff_h_d   = pend_h_q;
					waiting_d = 1'b0;
				end
				applied = 1'b1;
			end
			CMD_RESET: begin
				eff_w_d   = item.req_width;
				eff_h_d   = item.req_height;
				pend_w_d  = item.req_width;
				pend_h_d  = item.req_height;
				waiting_d = 1'b0;
				last_d    = '0;
			end
			default: begin
			end
		endcase
	end

	assign el_new     = item.now_ticks - last_d;
	assign el_new_ext = CMP_BITS'(el_new);
	assign left_ext   = (waiting_d && win_ext > el_new_ext) ? (win_ext - el_new_ext) : '0;

	always_comb begin
		result.applied      = applied;
		result.out_width    = eff_w_d;
		result.out_height   = eff_h_d;
		result.pending_flag = waiting_d;
		result.ticks_left   = left_ext[WIN_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WIN_RESET;
			eff_w_q   <= '0;
			eff_h_q   <= '0;
			pend_w_q  <= '0;
			pend_h_q  <= '0;
			waiting_q <= 1'b0;
			last_q    <= '0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (fire) begin
				eff_w_q   <= eff_w_d;
				eff_h_q   <= eff_h_d;
				pend_w_q  <= pend_w_d;
				pend_h_q  <= pend_h_d;
				waiting_q <= waiting_d;
				last_q    <= last_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/rrd_out_stage.sv
`default_nettype none
module rrd_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire rrd_pkg::out_item_t result,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rrd_pkg::out_item_t      out_data,
	output logic                    room
);
	import rrd_pkg::*;

	assign room = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (room) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= result;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/resize_request_debouncer_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (rrd_pkg::in_item_t)
// out       output     out_valid / out_ready out_data  (rrd_pkg::out_item_t)
// cfg       input      cfg_we                cfg_wdata (settle window)
//
// One item per cycle unless out stalls; out_valid rises as the result register loads.
// Input register feeds one pass of compare/subtract logic that updates the
// debounce state and loads the result register in the same cycle.
// arst_n clears valids and state; settle window resets to 1000 ticks.
// A stalled output holds the input register; in_ready drops only when both are full.
`default_nettype none
`include "resize_request_debouncer_core_defines.svh"
module resize_request_debouncer_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rrd_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rrd_pkg::out_item_t        out_data,
	input  wire logic                 cfg_we,
	input  wire logic [rrd_pkg::WIN_BITS-1:0] cfg_wdata
);
	import rrd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	out_item_t result;
	logic      room;
	logic      fire;

	assign fire = valid_s1 && room;

	rrd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (room),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rrd_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	rrd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.room      (room)
	);

	`RRD_ASSERT(a_full_blocks, clk, arst_n, (valid_s1 && out_valid && !out_ready) |-> !in_ready)
	`RRD_ASSERT(a_fire_delivers, clk, arst_n, fire |=> out_valid)
	`RRD_ASSERT(a_idle_no_left, clk, arst_n,
		out_valid |-> (out_data.pending_flag || out_data.ticks_left == '0))
	`RRD_ASSERT_ALWAYS(a_applied_clears, clk,
		(out_valid && out_data.applied) |-> !out_data.pending_flag)

endmodule
`default_nettype wire

FILE: dv/rrd_checker.sv
module rrd_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire rrd_pkg::in_item_t            in_data,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire rrd_pkg::out_item_t           out_data,
	input  wire logic                         cfg_we,
	input  wire logic [rrd_pkg::WIN_BITS-1:0] cfg_wdata,
	output int                                fail_count,
	output int                                owed_count
);
	import rrd_pkg::*;

	logic [WIN_BITS-1:0]        window;
	logic signed [DIM_BITS-1:0] eff_w, eff_h, pend_w, pend_h;
	logic                       waiting;
	logic [TIME_BITS-1:0]       last_req;
	out_item_t                  owed_status[$];

	initial fail_count = 0;

	task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		fail_count++;
		if (fail_count <= 50)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	task automatic settle_step(input in_item_t it, output out_item_t st);
		logic signed [DIM_BITS-1:0] w, h;
		logic [TIME_BITS-1:0]       el;
		logic                       hit;
		w = it.req_width;
		h = it.req_height;
		hit = 1'b0;
		case (it.command)
			CMD_REQUEST: begin
				if (w > 0 && h > 0) begin
					if (w == eff_w && h == eff_h) begin
						// back at the current size: drop the pending change
						if (waiting) begin
							waiting = 1'b0;
							pend_w = w;
							pend_h = h;
						end
					end else if (!waiting || w != pend_w || h != pend_h) begin
						pend_w = w;
						pend_h = h;
						last_req = it.now_ticks;
						waiting = 1'b1;
					end
				end
			end
			CMD_TICK: begin
				el = it.now_ticks - last_req;
				if (waiting && el >= window) begin
					eff_w = pend_w;
					eff_h = pend_h;
					waiting = 1'b0;
					hit = 1'b1;
				end
			end
			CMD_FLUSH: begin
				if (waiting) begin
					eff_w = pend_w;
					eff_h = pend_h;
					waiting = 1'b0;
				end
				hit = 1'b1;
			end
			CMD_RESET: begin
				eff_w = w;
				eff_h = h;
				pend_w = w;
				pend_h = h;
				waiting = 1'b0;
				last_req = '0;
			end
		endcase
		el = it.now_ticks - last_req;
		st.applied = hit;
		st.out_width = eff_w;
		st.out_height = eff_h;
		st.pending_flag = waiting;
		st.ticks_left = (waiting && window > el) ? window - el : '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want, fresh;
		if (!arst_n) begin
			window = WIN_RESET;
			eff_w = '0;
			eff_h = '0;
			pend_w = '0;
			pend_h = '0;
			waiting = 1'b0;
			last_req = '0;
			owed_status.delete();
		end else begin
			if (cfg_we)
				window = cfg_wdata;
			if (out_valid && out_ready) begin
				if (owed_status.size() == 0) begin
					flag_mismatch("item with nothing owed, width", out_data.out_width, 0);
				end else begin
					want = owed_status.pop_front();
					if (out_data.applied !== want.applied)
						flag_mismatch("applied", out_data.applied, want.applied);
					if (out_data.out_width !== want.out_width)
						flag_mismatch("out_width", out_data.out_width, want.out_width);
					if (out_data.out_height !== want.out_height)
						flag_mismatch("out_height", out_data.out_height, want.out_height);
					if (out_data.pending_flag !== want.pending_flag)
						flag_mismatch("pending_flag", out_data.pending_flag, want.pending_flag);
					if (out_data.ticks_left !== want.ticks_left)
						flag_mismatch("ticks_left", out_data.ticks_left, want.ticks_left);
				end
			end
			if (in_valid && in_ready) begin
				settle_step(in_data, fresh);
				owed_status = {owed_status, fresh};
			end
		end
		owed_count = owed_status.size();
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;
	import rrd_pkg::*;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	in_item_t                   in_data;
	logic                       out_valid;
	logic                       out_ready;
	out_item_t                  out_data;
	logic                       cfg_we;
	logic [WIN_BITS-1:0]        cfg_wdata;
	int                         fail_count;
	int                         owed_count;
	logic                       calm;
	logic [WIN_BITS-1:0]        win_now;
	logic [TIME_BITS-1:0]       now_t, req_t;
	logic signed [DIM_BITS-1:0] last_w, last_h, prev_w, prev_h;

	resize_request_debouncer_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rrd_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.owed_count (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DIM_BITS-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return DIM_BITS'($urandom_range(1, 4));
		if (r < 8) begin
			case ($urandom_range(0, 4))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return '0;
				3: return -1;
				default: return 1;
			endcase
		end
		return DIM_BITS'($urandom());
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] cmd, input logic signed [DIM_BITS-1:0] w,
			input logic signed [DIM_BITS-1:0] h, input logic [TIME_BITS-1:0] now);
		in_item_t it;
		int       gap;
		it.command = cmd;
		it.req_width = w;
		it.req_height = h;
		it.now_ticks = now;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (owed_count != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_window(input logic [WIN_BITS-1:0] v);
		wait_drained();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		win_now = v;
	endtask

	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			n = calm ? 0 : pick_gap();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	initial begin
		int                         r, s;
		logic [TIME_BITS-1:0]       t;
		logic [WIN_BITS-1:0]        v;
		logic signed [DIM_BITS-1:0] w, h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		win_now = WIN_RESET;
		now_t = '0;
		req_t = '0;
		last_w = 1;
		last_h = 1;
		prev_w = 1;
		prev_h = 1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default window of 1000
		send_item(CMD_TICK, 0, 0, 0);
		send_item(CMD_FLUSH, 0, 0, 0);
		send_item(CMD_REQUEST, 0, 5, 10);
		send_item(CMD_REQUEST, 5, -1, 10);
		send_item(CMD_REQUEST, 16'sh8000, 16'sh8000, 10);
		send_item(CMD_REQUEST, 16'sh7FFF, 16'sh7FFF, 100);
		send_item(CMD_TICK, 0, 0, 1099);
		send_item(CMD_TICK, 0, 0, 1100);
		send_item(CMD_REQUEST, 16'sh7FFF, 16'sh7FFF, 1200);
		send_item(CMD_REQUEST, 1, 1, 2000);
		send_item(CMD_REQUEST, 1, 1, 2500);
		send_item(CMD_TICK, 0, 0, 3000);
		send_item(CMD_REQUEST, 2, 2, 4000);
		send_item(CMD_REQUEST, 1, 1, 4100);
		send_item(CMD_REQUEST, 3, 4, 10);
		send_item(CMD_TICK, 0, 0, 5);
		send_item(CMD_RESET, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF);
		send_item(CMD_REQUEST, 7, 8, 32'hFFFF_FF00);
		send_item(CMD_TICK, 0, 0, 32'h0000_02E7);
		send_item(CMD_TICK, 0, 0, 32'h0000_02E8);
		send_item(CMD_REQUEST, 9, 9, 5);
		send_item(CMD_FLUSH, 0, 0, 6);
		send_item(CMD_RESET, 0, 0, 0);
		set_window('0);
		send_item(CMD_REQUEST, 1, 2, 50);
		send_item(CMD_TICK, -1, -1, 50);
		set_window('1);
		send_item(CMD_REQUEST, 3, 3, 0);
		send_item(CMD_TICK, 0, 0, 32'hFFFF_FFFE);
		send_item(CMD_TICK, 0, 0, 32'hFFFF_FFFF);

		for (int p = 0; p < 10; p++) begin
			case ($urandom_range(0, 7))
				0: v = '0;
				1: v = 1;
				2: v = $urandom_range(2, 20);
				3: v = WIN_RESET;
				4: v = $urandom_range(20, 5000);
				5: v = '1;
				6: v = $urandom();
				default: v = 32'h8000_0000 + $urandom_range(0, 50);
			endcase
			set_window(v);
			calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 100; i++) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					s = $urandom_range(0, 9);
					if (s < 2) begin
						w = last_w;
						h = last_h;
					end else if (s < 4) begin
						w = prev_w;
						h = prev_h;
					end else begin
						w = pick_dim();
						h = pick_dim();
					end
					if (w != last_w || h != last_h) begin
						prev_w = last_w;
						prev_h = last_h;
						last_w = w;
						last_h = h;
					end
					now_t += $urandom_range(0, 40);
					req_t = now_t;
					send_item(CMD_REQUEST, w, h, now_t);
				end else if (r < 60) begin
					s = $urandom_range(0, 9);
					if (s < 5) begin
						// land on the window edge: one short, exact, one past
						t = req_t + win_now + $urandom_range(0, 2) - 1;
						now_t = t;
					end else if (s < 8) begin
						now_t += $urandom_range(0, 3000);
						t = now_t;
					end else begin
						t = $urandom();
					end
					send_item(CMD_TICK, DIM_BITS'($urandom()), DIM_BITS'($urandom()), t);
				end else if (r < 70) begin
					send_item(CMD_FLUSH, DIM_BITS'($urandom()), DIM_BITS'($urandom()), now_t);
				end else if (r < 75) begin
					send_item(CMD_RESET, pick_dim(), pick_dim(), $urandom());
				end else begin
					send_item(2'($urandom_range(0, 3)), DIM_BITS'($urandom()),
						DIM_BITS'($urandom()), $urandom());
				end
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: resize_request_debouncer_core.f
+incdir+hdl
hdl/rrd_pkg.sv
hdl/rrd_in_stage.sv
hdl/rrd_update.sv
hdl/rrd_out_stage.sv
hdl/resize_request_debouncer_core.sv
dv/rrd_checker.sv
dv/tb_top.sv
